// ----- src/fskm_pkg.sv -----
// ----------------------------------------------------------------------------
// fskm_pkg - shared types and constants for the four-level FSK modulator
// Level table, register indexes, field widths and the result structure.
// ----------------------------------------------------------------------------
package fskm_pkg;

  localparam int HOLD_WIDTH = 16;
  localparam int DAC_BITS   = 12;
  localparam int QP_WIDTH   = 16;
  localparam int CPS_WIDTH  = 8;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_QP0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QP1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QP2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_QP3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CPS = 3'd4;

  localparam logic [QP_WIDTH-1:0]  QP0_RESET = 16'd500;
  localparam logic [QP_WIDTH-1:0]  QP1_RESET = 16'd333;
  localparam logic [QP_WIDTH-1:0]  QP2_RESET = 16'd250;
  localparam logic [QP_WIDTH-1:0]  QP3_RESET = 16'd200;
  localparam logic [CPS_WIDTH-1:0] CPS_RESET = 8'd5;

  localparam logic [31:0] LEVEL_MID = 32'd500;
  localparam logic [31:0] LEVEL_TOP = 32'd1000;
  localparam logic [31:0] DAC_MAX   = 32'((64'd1 << DAC_BITS) - 64'd1);
  localparam logic [31:0] HOLD_MAX  = 32'((64'd1 << HOLD_WIDTH) - 64'd1);

  // Tdata widths, rounded up to whole bytes
  localparam int IN_DATA_W  = 8;
  localparam int OUT_FLD_W  = DAC_BITS + 4;
  localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

  typedef logic [QP_WIDTH-1:0] qp_t;

  typedef struct packed {
    qp_t [3:0]            quarter_period;
    logic [CPS_WIDTH-1:0] cycles_per_symbol;
  } cfg_t;

  typedef struct packed {
    logic [1:0]          current_symbol;
    logic                byte_accepted;
    logic                busy_res;
    logic [DAC_BITS-1:0] dac_code;
  } res_t;

  function automatic logic [DAC_BITS-1:0] sat_level(input logic [31:0] v);
    logic [31:0] s;
    s = (v > DAC_MAX) ? DAC_MAX : v;
    return s[DAC_BITS-1:0];
  endfunction

  // Level sequence of one tone cycle: mid, top, mid, zero
  function automatic logic [DAC_BITS-1:0] phase_level(input logic [1:0] phase);
    logic [DAC_BITS-1:0] lvl;
    unique case (phase)
      2'd0:    lvl = sat_level(LEVEL_MID);
      2'd1:    lvl = sat_level(LEVEL_TOP);
      2'd2:    lvl = sat_level(LEVEL_MID);
      default: lvl = '0;
    endcase
    return lvl;
  endfunction

endpackage

// ----- src/fskm_cfg.sv -----
// ----------------------------------------------------------------------------
// fskm_cfg - configuration register file
// Holds the four quarter periods and the tone cycle count per symbol.
// ----------------------------------------------------------------------------
module fskm_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fskm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fskm_pkg::QP_WIDTH-1:0]       cfg_data,
  output fskm_pkg::cfg_t                      cfg
);
  import fskm_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.quarter_period[0] <= QP0_RESET;
      cfg_r.quarter_period[1] <= QP1_RESET;
      cfg_r.quarter_period[2] <= QP2_RESET;
      cfg_r.quarter_period[3] <= QP3_RESET;
      cfg_r.cycles_per_symbol <= CPS_RESET;
    end else if (cfg_valid) begin
      // unknown indexes are dropped
      unique case (cfg_index)
        REG_QP0: cfg_r.quarter_period[0] <= cfg_data;
        REG_QP1: cfg_r.quarter_period[1] <= cfg_data;
        REG_QP2: cfg_r.quarter_period[2] <= cfg_data;
        REG_QP3: cfg_r.quarter_period[3] <= cfg_data;
        REG_CPS: cfg_r.cycles_per_symbol <= cfg_data[CPS_WIDTH-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- src/fskm_seq.sv -----
// ----------------------------------------------------------------------------
// fskm_seq - symbol, cycle, phase and hold sequencer
// Updates the transmit state on each transfer and forms its result.
// ----------------------------------------------------------------------------
module fskm_seq (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             step_valid,
  input  logic                             req_type,
  input  logic [7:0]                       data_byte,
  input  fskm_pkg::cfg_t                   cfg,
  output fskm_pkg::res_t                   res
);
  import fskm_pkg::*;

  logic [7:0]            byte_hold_r,    byte_hold_nxt;
  logic [1:0]            symbol_count_r, symbol_count_nxt;
  logic [7:0]            cycle_count_r,  cycle_count_nxt;
  logic [1:0]            phase_count_r,  phase_count_nxt;
  logic [HOLD_WIDTH-1:0] hold_count_r,   hold_count_nxt;
  logic                  active_r,       active_nxt;

  logic [1:0]            sym_now;
  logic [31:0]           qp_ext;
  logic [HOLD_WIDTH-1:0] eff_period;
  logic [7:0]            eff_cycles;
  logic [HOLD_WIDTH-1:0] hold_inc;
  logic                  accepted;

  // Period of the symbol being sent, zero taken as one, clipped to the counter
  always_comb begin
    sym_now    = 2'(byte_hold_r >> {symbol_count_r, 1'b0});
    qp_ext     = 32'(cfg.quarter_period[sym_now]);
    if (qp_ext == 32'd0) qp_ext = 32'd1;
    if (qp_ext > HOLD_MAX) qp_ext = HOLD_MAX;
    eff_period = qp_ext[HOLD_WIDTH-1:0];
    eff_cycles = (cfg.cycles_per_symbol == '0) ? 8'd1 : cfg.cycles_per_symbol;
    hold_inc   = hold_count_r + 1'b1;
  end

  always_comb begin
    byte_hold_nxt    = byte_hold_r;
    symbol_count_nxt = symbol_count_r;
    cycle_count_nxt  = cycle_count_r;
    phase_count_nxt  = phase_count_r;
    hold_count_nxt   = hold_count_r;
    active_nxt       = active_r;
    accepted         = 1'b0;
    if (req_type) begin
      if (!active_r) begin
        byte_hold_nxt    = data_byte;
        symbol_count_nxt = '0;
        cycle_count_nxt  = '0;
        phase_count_nxt  = '0;
        hold_count_nxt   = '0;
        active_nxt       = 1'b1;
        accepted         = 1'b1;
      end
    end else if (active_r) begin
      hold_count_nxt = hold_inc;
      if (hold_inc >= eff_period) begin
        hold_count_nxt  = '0;
        phase_count_nxt = phase_count_r + 2'd1;
        if (phase_count_r == 2'd3) begin
          cycle_count_nxt = cycle_count_r + 8'd1;
          if (cycle_count_r + 8'd1 >= eff_cycles) begin
            cycle_count_nxt = '0;
            if (symbol_count_r == 2'd3) begin
              symbol_count_nxt = '0;
              active_nxt       = 1'b0;
            end else begin
              symbol_count_nxt = symbol_count_r + 2'd1;
            end
          end
        end
      end
    end
  end

  // Result reflects the state after this transfer
  always_comb begin
    res.byte_accepted = accepted;
    res.busy_res      = active_nxt;
    if (active_nxt) begin
      res.dac_code       = phase_level(phase_count_nxt);
      res.current_symbol = 2'(byte_hold_nxt >> {symbol_count_nxt, 1'b0});
    end else begin
      res.dac_code       = '0;
      res.current_symbol = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_hold_r    <= '0;
      symbol_count_r <= '0;
      cycle_count_r  <= '0;
      phase_count_r  <= '0;
      hold_count_r   <= '0;
      active_r       <= 1'b0;
    end else if (step_valid) begin
      byte_hold_r    <= byte_hold_nxt;
      symbol_count_r <= symbol_count_nxt;
      cycle_count_r  <= cycle_count_nxt;
      phase_count_r  <= phase_count_nxt;
      hold_count_r   <= hold_count_nxt;
      active_r       <= active_nxt;
    end
  end

  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> (symbol_count_r == '0) && (cycle_count_r == '0) &&
                  (phase_count_r == '0) && (hold_count_r == '0))
    else $error("idle sequencer holds stale counters");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (step_valid && req_type && !active_r) |=>
      active_r && (hold_count_r == '0) && (byte_hold_r == $past(data_byte)))
    else $error("accepted byte did not start transmission");

  a_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (step_valid && req_type && active_r) |=>
      $stable(byte_hold_r) && $stable(hold_count_r) && $stable(phase_count_r))
    else $error("rejected byte disturbed transmit state");

  a_hold_bound: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (hold_count_r < eff_period) || $changed(cfg))
    else $error("hold count reached its period");

endmodule

// ----- src/four_level_fsk_modulator.sv -----
// ----------------------------------------------------------------------------
// four_level_fsk_modulator - 4-FSK transmitter producing DAC codes
// Sends each byte as four 2-bit symbols, each a tone of programmable period.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one item per transfer. in_tuser is the request kind (0 = one
//            microsecond tick, 1 = byte offer), in_tdata the byte.
//   out_*  : exactly one result per input item, in order: DAC code, busy flag,
//            byte-taken flag and the symbol being sent.
//   cfg_*  : register writes (index 0..3 quarter periods, index 4 the per-symbol tone count);
//            write only while no input item is offered; while a byte is
//            being sent, change a period only at a level boundary.
// Throughput is one item per clock while out_tready is high; the result of an
// input transfer appears in the output register in the cycle after it.
// A single result register separates the channels: in_tready is high while
// that register is empty or being emptied, so a stalled receiver holds the
// pending result and back-pressures the input without losing state.
// Reset clears the transmit state (idle, DAC 0), empties the output register
// and restores the register defaults 500, 333, 250, 200 and 5.
// ----------------------------------------------------------------------------
module four_level_fsk_modulator (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [fskm_pkg::IN_DATA_W-1:0]     in_tdata,   // [7:0] data_byte
  input  logic                               in_tuser,   // [0] req_type
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // from bit 0: dac_code, busy_res, byte_accepted, current_symbol
  output logic [fskm_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fskm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fskm_pkg::QP_WIDTH-1:0]      cfg_data
);
  import fskm_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t res_r;
  logic out_valid_r;
  logic in_xfer;

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  fskm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fskm_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_valid (in_xfer),
    .req_type   (in_tuser),
    .data_byte  (in_tdata),
    .cfg        (cfg),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(res_r);

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !in_tready)
    else $error("input accepted over a stalled result");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.busy_res) |->
      (res_r.dac_code == '0) && (res_r.current_symbol == '0))
    else $error("idle result carries nonzero level or symbol");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.byte_accepted) |->
      res_r.busy_res && (res_r.dac_code == sat_level(LEVEL_MID)))
    else $error("accepted byte did not start at mid level");

endmodule

// ----- tb/tb_four_level_fsk_modulator.sv -----
// ----------------------------------------------------------------------------
// tb_four_level_fsk_modulator - self-checking bench for the 4-FSK modulator
// Streams tick and byte-offer items into the block and checks every result
// against a cycle-free model of the transmit sequencer held in the bench.
// Covers the register defaults, zero registers and the full-scale cycle count,
// rejected offers, long back-pressure, random small configurations and idle bursts.
// ----------------------------------------------------------------------------
module tb_four_level_fsk_modulator;
  import fskm_pkg::*;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_BYTE = 1'b1;

  localparam int LONG_HOLD    = 150;
  localparam int RANDOM_ITEMS = 320;
  localparam int RANDOM_SETS  = 8;
  localparam int LIMIT        = 3_000_000;

  // Levels of one tone cycle, indexed by phase
  localparam logic [3:0][DAC_BITS-1:0] TONE_LEVEL = {
    {DAC_BITS{1'b0}}, LEVEL_MID[DAC_BITS-1:0], LEVEL_TOP[DAC_BITS-1:0],
    LEVEL_MID[DAC_BITS-1:0]
  };

  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic                    in_tvalid  = 1'b0;
  logic                    in_tready;
  logic [IN_DATA_W-1:0]    in_tdata   = '0;
  logic                    in_tuser   = 1'b0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   out_tdata;
  logic                    cfg_valid  = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index  = '0;
  logic [QP_WIDTH-1:0]     cfg_data   = '0;

  four_level_fsk_modulator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bench copy of the registers and the transmit state
  qp_t            qp_reg [4];
  logic [7:0]     cps_reg;
  logic [7:0]     tone_byte;
  logic [1:0]     sym_idx;
  logic [7:0]     cyc_idx;
  logic [1:0]     phase_idx;
  logic [15:0]    tick_cnt;
  logic           sending;

  res_t           pending_out [$];
  int             items_sent   = 0;
  int             results_seen = 0;
  int             err_cnt      = 0;
  int             cycle_cnt    = 0;

  bit             tx_idle_on   = 1'b0;
  logic           rx_idle_on   = 1'b0;
  int             hold_reqs    = 0;
  int             hold_seen    = 0;
  int             rx_wait      = 0;

  function automatic logic [1:0] tone_symbol();
    logic [7:0] s;
    s = tone_byte >> (2 * sym_idx);
    return s[1:0];
  endfunction

  function automatic res_t modulate_step(input logic req, input logic [7:0] b);
    res_t        r;
    logic [15:0] period;
    logic [7:0]  cycles;
    r = '0;
    if (req == REQ_BYTE) begin
      if (!sending) begin
        tone_byte       = b;
        sym_idx         = '0;
        cyc_idx         = '0;
        phase_idx       = '0;
        tick_cnt        = '0;
        sending         = 1'b1;
        r.byte_accepted = 1'b1;
      end
    end else if (sending) begin
      period = qp_reg[tone_symbol()];
      if (period == '0) period = 16'd1;
      cycles = (cps_reg == '0) ? 8'd1 : cps_reg;
      tick_cnt = tick_cnt + 16'd1;
      if (tick_cnt >= period) begin
        tick_cnt  = '0;
        phase_idx = phase_idx + 2'd1;
        if (phase_idx == 2'd0) begin
          cyc_idx = cyc_idx + 8'd1;
          if (cyc_idx >= cycles) begin
            cyc_idx = '0;
            if (sym_idx == 2'd3) begin
              sym_idx = '0;
              sending = 1'b0;
            end else begin
              sym_idx = sym_idx + 2'd1;
            end
          end
        end
      end
    end
    if (sending) begin
      r.dac_code       = TONE_LEVEL[phase_idx];
      r.busy_res       = 1'b1;
      r.current_symbol = tone_symbol();
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    err_cnt++;
    if (err_cnt <= 40)
      $display("mismatch at result %0d: %s got %0d expected %0d",
               results_seen, what, got, want);
  endtask

  // Result checker: values at the falling edge are the ones the next rising
  // edge transfers
  always @(negedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = res_t'(out_tdata);
      if (pending_out.size() == 0) begin
        report_mismatch("result with none expected, data", int'(out_tdata), 0);
      end else begin
        want = pending_out.pop_front();
        if (got.dac_code != want.dac_code)
          report_mismatch("dac_code", int'(got.dac_code), int'(want.dac_code));
        if (got.busy_res != want.busy_res)
          report_mismatch("busy_res", int'(got.busy_res), int'(want.busy_res));
        if (got.byte_accepted != want.byte_accepted)
          report_mismatch("byte_accepted", int'(got.byte_accepted),
                          int'(want.byte_accepted));
        if (got.current_symbol != want.current_symbol)
          report_mismatch("current_symbol", int'(got.current_symbol),
                          int'(want.current_symbol));
      end
      results_seen++;
    end
  end

  // Receiver: random stall bursts, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      rx_wait   = LONG_HOLD;
    end
    if (rx_wait > 0) begin
      rx_wait--;
      out_tready <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
      rx_wait = $urandom_range(0, 6);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offer one item; valid stays high so back-to-back items need no gap
  task automatic send_item(input logic req, input logic [7:0] b);
    int gap;
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_out.push_back(modulate_step(req, b));
    items_sent++;
  endtask

  // Offer a byte, then tick until it is fully sent, with stray offers mixed in
  task automatic run_byte(input logic [7:0] b, input int reject_pct);
    send_item(REQ_BYTE, b);
    while (sending) begin
      if ($urandom_range(0, 99) < reject_pct)
        send_item(REQ_BYTE, 8'($urandom));
      else
        send_item(REQ_TICK, 8'($urandom));
    end
  endtask

  // Tick until the byte in progress is fully sent
  task automatic finish_byte();
    while (sending) send_item(REQ_TICK, 8'($urandom));
  endtask

  // Drop valid and drain every expected result
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [QP_WIDTH-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx <= REG_QP3)
      qp_reg[idx[1:0]] = val;
    else if (idx == REG_CPS)
      cps_reg = val[CPS_WIDTH-1:0];
  endtask

  task automatic set_config(input qp_t q0, input qp_t q1, input qp_t q2, input qp_t q3,
                            input logic [7:0] c);
    write_reg(REG_QP0, q0);
    write_reg(REG_QP1, q1);
    write_reg(REG_QP2, q2);
    write_reg(REG_QP3, q3);
    // upper bits of the cycle count write are don't-care
    write_reg(REG_CPS, {8'($urandom), c});
    cfg_valid <= 1'b0;
  endtask

  task automatic random_small_config();
    set_config(qp_t'($urandom_range(0, 4)), qp_t'($urandom_range(0, 4)),
               qp_t'($urandom_range(0, 4)), qp_t'($urandom_range(0, 4)),
               8'($urandom_range(0, 3)));
  endtask

  task automatic set_idling(input bit on);
    tx_idle_on = on;
    rx_idle_on <= on;
  endtask

  task automatic test_reset_defaults();
    set_idling(1'b0);
    send_item(REQ_TICK, 8'hA5);
    // low pair 3 goes first: hold one level for the default symbol-3 period
    send_item(REQ_BYTE, 8'h1B);
    send_item(REQ_BYTE, 8'h5A);
    while (phase_idx == 2'd0) send_item(REQ_TICK, 8'($urandom));
    settle();
    // shorten the periods at the level boundary, keep the default cycle count
    write_reg(REG_QP0, 16'd1);
    write_reg(REG_QP1, 16'd1);
    write_reg(REG_QP2, 16'd1);
    write_reg(REG_QP3, 16'd1);
    cfg_valid <= 1'b0;
    finish_byte();
    settle();
  endtask

  task automatic test_zero_registers();
    set_idling(1'b1);
    set_config('0, '0, '0, '0, 8'd0);
    run_byte(8'hE4, 20);
    settle();
  endtask

  task automatic test_edge_bytes();
    set_config(16'd1, 16'd2, 16'd3, 16'd4, 8'd2);
    run_byte(8'h00, 10);
    run_byte(8'hFF, 10);
    settle();
  endtask

  task automatic test_unused_index();
    write_reg(REG_CPS + 3'd1, 16'($urandom));
    write_reg(REG_CPS + 3'd2, 16'($urandom));
    write_reg(REG_CPS + 3'd3, 16'($urandom));
    cfg_valid <= 1'b0;
    run_byte(8'($urandom), 10);
    settle();
  endtask

  task automatic test_max_cycles();
    set_idling(1'b0);
    set_config(16'd1, 16'd1, 16'd1, 16'd1, 8'd255);
    send_item(REQ_BYTE, 8'($urandom));
    while (cyc_idx < 8'd64) send_item(REQ_TICK, 8'($urandom));
    settle();
    // unit periods keep the hold count at zero; cut the symbol short
    write_reg(REG_CPS, 16'd1);
    cfg_valid <= 1'b0;
    finish_byte();
    settle();
  endtask

  task automatic test_long_period();
    set_config(16'd1, 16'd1, 16'd1, 16'd64, 8'd1);
    // first symbol uses the long period, the rest the shortest
    run_byte(8'h03, 0);
    settle();
  endtask

  task automatic test_back_pressure();
    set_idling(1'b1);
    random_small_config();
    hold_reqs <= hold_reqs + 1;
    run_byte(8'($urandom), 10);
    run_byte(8'($urandom), 10);
    settle();
  endtask

  task automatic test_random_sets();
    int start;
    set_idling(1'b1);
    for (int s = 0; s < RANDOM_SETS; s++) begin
      random_small_config();
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS / RANDOM_SETS) begin
        if ($urandom_range(0, 9) == 0)
          send_item(REQ_TICK, 8'($urandom));
        else
          run_byte(8'($urandom), 10);
      end
      settle();
    end
  endtask

  task automatic test_steady_stream();
    int start;
    set_idling(1'b0);
    random_small_config();
    start = items_sent;
    while (items_sent - start < 100) run_byte(8'($urandom), 10);
    settle();
  endtask

  initial begin
    qp_reg[0] = QP0_RESET;
    qp_reg[1] = QP1_RESET;
    qp_reg[2] = QP2_RESET;
    qp_reg[3] = QP3_RESET;
    cps_reg   = CPS_RESET;
    tone_byte = '0;
    sym_idx   = '0;
    cyc_idx   = '0;
    phase_idx = '0;
    tick_cnt  = '0;
    sending   = 1'b0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_zero_registers();
    test_edge_bytes();
    test_unused_index();
    test_max_cycles();
    test_long_period();
    test_back_pressure();
    test_random_sets();
    test_steady_stream();

    repeat (5) @(posedge clk);
    if (pending_out.size() != 0)
      report_mismatch("results left outstanding", pending_out.size(), 0);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
